>>> src/fpd_pkg.sv
// Shared types and constants for the FM polar discriminator.
`timescale 1ns / 1ps

package fpd_pkg;

    // Fixed-point widths
    localparam int FRAC_W      = 16;                   // Q16 fraction bits
    localparam int QUOT_W      = 17;                   // quotient bits, ratio 0..65536
    localparam int CNT_W       = $clog2(QUOT_W + 1);   // divider step counter
    localparam int ANG_W       = 18;                   // angle 0..pi in Q16
    localparam int GAIN_W      = 16;                   // Q2.14 gain
    localparam int OUT_W       = 16;                   // Q3.12 output
    localparam int POLY_W      = 15;                   // B + C*d term
    localparam int DN_W        = 17;                   // rational denominator
    localparam int SCALE_SHIFT = 18;                   // Q16 * Q14 -> Q12

    // Arctangent coefficients in Q16
    localparam logic [DN_W-1:0]   COEF_A = 17'd64500;
    localparam logic [POLY_W-1:0] COEF_B = 15'd6127;
    localparam logic [POLY_W-1:0] COEF_C = 15'd12816;

    // Angle constants in Q16 radians
    localparam logic [ANG_W-1:0] PI_Q16      = 18'd205887;
    localparam logic [ANG_W-1:0] HALF_PI_Q16 = 18'd102944;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd11682;
    localparam logic [QUOT_W-1:0] RATIO_ONE  = 17'd65536;

    localparam logic [OUT_W-1:0] OUT_MAX = 16'h7FFF;
    localparam logic [OUT_W-1:0] OUT_MIN = 16'h8000;

    // Round-to-nearest offsets
    localparam int ROUND_POLY  = 1 << (FRAC_W - 1);
    localparam int ROUND_SCALE = 1 << (SCALE_SHIFT - 1);

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_IM,
        ST_FOLD,
        ST_PREP,
        ST_DIV_RATIO,
        ST_POLY_C,
        ST_POLY_Q,
        ST_POLY_DQ,
        ST_POLY_DEN,
        ST_DIV_ATAN,
        ST_ANGLE,
        ST_SAT
    } fpd_state_t;

endpackage

>>> src/fm_polar_discriminator.sv
// FM polar discriminator top level: sequencer around a shared multiplier and divider.
// A new input word is taken only in idle, after the last one was loaded for output.
// Each word runs two 17-step divisions in the shared radix-2 divider plus seven passes
// through the shared multiplier; a zero product skips the divisions and two passes.
// Reset (aresetn low, synchronous): sequencer idle, no output word pending,
// previous sample cleared to zero, gain register back to 11682.
`timescale 1ns / 1ps

module fm_polar_discriminator #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Gain register write
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fpd_pkg::GAIN_W-1:0]            cfg_data,
    // Input samples
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_in_i,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_in_q,
    // Demodulated output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [fpd_pkg::OUT_W-1:0]      m_demod_out
);

    localparam int W      = SAMPLE_WIDTH;
    localparam int RE_W   = 2 * W + 1;
    localparam int MAG_W  = 2 * W;
    localparam int DEN_W  = (MAG_W > fpd_pkg::QUOT_W) ? MAG_W : fpd_pkg::QUOT_W;
    localparam int MUL_W  = (W > fpd_pkg::ANG_W) ? W : fpd_pkg::ANG_W + 1;
    localparam int PROD_W = 2 * MUL_W;

    fpd_pkg::fpd_state_t state_reg, state_next;

    logic signed [W-1:0]            prev_i_reg, prev_q_reg;
    logic signed [W-1:0]            cur_i_reg, cur_q_reg;
    logic signed [RE_W-1:0]         acc_reg, re_reg, im_reg;
    logic [MAG_W-1:0]               ax_reg, y_reg;
    logic                           re_neg_reg, im_neg_reg, zero_reg, swap_reg;
    logic [fpd_pkg::QUOT_W-1:0]     d_reg;
    logic [fpd_pkg::POLY_W-1:0]     q_reg;
    logic [fpd_pkg::ANG_W-1:0]      ang_reg;
    logic [fpd_pkg::GAIN_W-1:0]     gain_reg;
    logic                           m_valid_reg;
    logic [fpd_pkg::OUT_W-1:0]      m_demod_out_reg;

    logic                           mul_en;
    logic signed [MUL_W-1:0]        op_a, op_b;
    logic signed [PROD_W-1:0]       prod;
    logic signed [PROD_W-1:0]       rnd_sum, scale_sum;

    logic                           div_start, div_busy;
    logic [DEN_W-1:0]               div_num, div_den;
    logic [fpd_pkg::QUOT_W-1:0]     div_quot;

    logic                           in_accept, out_free, out_load;
    logic [fpd_pkg::DN_W-1:0]       dn;
    logic [fpd_pkg::ANG_W-1:0]      t_ext, ang_calc;
    logic [fpd_pkg::OUT_W-1:0]      mag, out_val;

    // Shared units
    fpd_mul #(.MUL_W(MUL_W)) u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    fpd_div #(.DEN_W(DEN_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    assign s_ready   = (state_reg == fpd_pkg::ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // Rounded taps off the product: Q16 for the polynomial, Q12 for the output
    assign rnd_sum   = prod + PROD_W'(fpd_pkg::ROUND_POLY);
    assign scale_sum = prod + PROD_W'(fpd_pkg::ROUND_SCALE);
    assign dn        = fpd_pkg::COEF_A + rnd_sum[fpd_pkg::FRAC_W +: fpd_pkg::DN_W];

    // Octant unfold
    assign t_ext = fpd_pkg::ANG_W'(div_quot);
    always_comb begin
        if (swap_reg) begin
            ang_calc = re_neg_reg ? fpd_pkg::HALF_PI_Q16 + t_ext
                                  : fpd_pkg::HALF_PI_Q16 - t_ext;
        end else begin
            ang_calc = re_neg_reg ? fpd_pkg::PI_Q16 - t_ext : t_ext;
        end
    end

    // Gain rounding, sign and saturation
    assign mag = scale_sum[fpd_pkg::SCALE_SHIFT +: fpd_pkg::OUT_W];
    always_comb begin
        if (im_neg_reg) begin
            out_val = (mag > fpd_pkg::OUT_MIN) ? fpd_pkg::OUT_MIN
                                               : fpd_pkg::OUT_W'(~mag + 1'b1);
        end else begin
            out_val = (mag > fpd_pkg::OUT_MAX) ? fpd_pkg::OUT_MAX : mag;
        end
    end

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fpd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state, operand select and unit control
    always_comb begin
        state_next = state_reg;
        mul_en     = 1'b0;
        op_a       = '0;
        op_b       = '0;
        div_start  = 1'b0;
        div_num    = DEN_W'(y_reg);
        div_den    = DEN_W'(ax_reg);
        out_load   = 1'b0;
        unique case (state_reg)
            fpd_pkg::ST_IDLE: begin
                if (in_accept) begin
                    state_next = fpd_pkg::ST_MUL0;
                end
            end
            fpd_pkg::ST_MUL0: begin
                mul_en     = 1'b1;
                op_a       = MUL_W'(prev_i_reg);
                op_b       = MUL_W'(cur_i_reg);
                state_next = fpd_pkg::ST_MUL1;
            end
            fpd_pkg::ST_MUL1: begin
                mul_en     = 1'b1;
                op_a       = MUL_W'(prev_q_reg);
                op_b       = MUL_W'(cur_q_reg);
                state_next = fpd_pkg::ST_MUL2;
            end
            fpd_pkg::ST_MUL2: begin
                mul_en     = 1'b1;
                op_a       = MUL_W'(prev_i_reg);
                op_b       = MUL_W'(cur_q_reg);
                state_next = fpd_pkg::ST_MUL3;
            end
            fpd_pkg::ST_MUL3: begin
                mul_en     = 1'b1;
                op_a       = MUL_W'(cur_i_reg);
                op_b       = MUL_W'(prev_q_reg);
                state_next = fpd_pkg::ST_IM;
            end
            fpd_pkg::ST_IM: begin
                state_next = fpd_pkg::ST_FOLD;
            end
            fpd_pkg::ST_FOLD: begin
                state_next = fpd_pkg::ST_PREP;
            end
            fpd_pkg::ST_PREP: begin
                if (zero_reg) begin
                    state_next = fpd_pkg::ST_ANGLE;
                end else begin
                    div_start  = 1'b1;
                    div_num    = (ax_reg < y_reg) ? DEN_W'(ax_reg) : DEN_W'(y_reg);
                    div_den    = (ax_reg < y_reg) ? DEN_W'(y_reg) : DEN_W'(ax_reg);
                    state_next = fpd_pkg::ST_DIV_RATIO;
                end
            end
            fpd_pkg::ST_DIV_RATIO: begin
                if (!div_busy) begin
                    state_next = fpd_pkg::ST_POLY_C;
                end
            end
            fpd_pkg::ST_POLY_C: begin
                mul_en     = 1'b1;
                op_a       = MUL_W'(fpd_pkg::COEF_C);
                op_b       = MUL_W'(d_reg);
                state_next = fpd_pkg::ST_POLY_Q;
            end
            fpd_pkg::ST_POLY_Q: begin
                state_next = fpd_pkg::ST_POLY_DQ;
            end
            fpd_pkg::ST_POLY_DQ: begin
                mul_en     = 1'b1;
                op_a       = MUL_W'(d_reg);
                op_b       = MUL_W'(q_reg);
                state_next = fpd_pkg::ST_POLY_DEN;
            end
            fpd_pkg::ST_POLY_DEN: begin
                div_start  = 1'b1;
                div_num    = DEN_W'(d_reg);
                div_den    = DEN_W'(dn);
                state_next = fpd_pkg::ST_DIV_ATAN;
            end
            fpd_pkg::ST_DIV_ATAN: begin
                if (!div_busy) begin
                    state_next = fpd_pkg::ST_ANGLE;
                end
            end
            fpd_pkg::ST_ANGLE: begin
                // Scale pass: angle times gain
                mul_en     = 1'b1;
                op_a       = MUL_W'(zero_reg ? '0 : ang_calc);
                op_b       = MUL_W'(gain_reg);
                state_next = fpd_pkg::ST_SAT;
            end
            fpd_pkg::ST_SAT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = fpd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fpd_pkg::ST_IDLE;
            end
        endcase
    end

    // Sample history and gain register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_i_reg <= '0;
            prev_q_reg <= '0;
            gain_reg   <= fpd_pkg::GAIN_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                gain_reg <= cfg_data;
            end
            if (state_reg == fpd_pkg::ST_IM) begin
                prev_i_reg <= cur_i_reg;
                prev_q_reg <= cur_q_reg;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cur_i_reg <= s_in_i;
            cur_q_reg <= s_in_q;
        end
        case (state_reg)
            fpd_pkg::ST_MUL1: acc_reg <= RE_W'(prod);
            fpd_pkg::ST_MUL2: re_reg  <= acc_reg + RE_W'(prod);
            fpd_pkg::ST_MUL3: acc_reg <= RE_W'(prod);
            fpd_pkg::ST_IM:   im_reg  <= acc_reg - RE_W'(prod);
            fpd_pkg::ST_FOLD: begin
                re_neg_reg <= re_reg[RE_W-1];
                im_neg_reg <= im_reg[RE_W-1];
                ax_reg     <= re_reg[RE_W-1] ? MAG_W'(-re_reg) : MAG_W'(re_reg);
                y_reg      <= im_reg[RE_W-1] ? MAG_W'(-im_reg) : MAG_W'(im_reg);
                zero_reg   <= (re_reg == '0) && (im_reg == '0);
            end
            fpd_pkg::ST_PREP: swap_reg <= (ax_reg < y_reg);
            fpd_pkg::ST_DIV_RATIO: begin
                if (!div_busy) begin
                    d_reg <= div_quot;
                end
            end
            fpd_pkg::ST_POLY_Q: begin
                q_reg <= fpd_pkg::COEF_B + rnd_sum[fpd_pkg::FRAC_W +: fpd_pkg::POLY_W];
            end
            fpd_pkg::ST_ANGLE: ang_reg <= zero_reg ? '0 : ang_calc;
            default: begin
            end
        endcase
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_demod_out_reg <= out_val;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_demod_out = m_demod_out_reg;

    // Divider is only started when free
    a_div_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // Folded ratio never exceeds one
    a_ratio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fpd_pkg::ST_DIV_RATIO && !div_busy) |-> (div_quot <= fpd_pkg::RATIO_ONE))
        else $error("folded ratio out of range");

    // Unfolded angle stays within 0..pi
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fpd_pkg::ST_SAT) |-> (ang_reg <= fpd_pkg::PI_Q16))
        else $error("angle above pi");

    // A negative phase step never gives a positive output word
    a_neg_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && im_neg_reg) |=> (m_demod_out_reg[fpd_pkg::OUT_W-1]
                                      || m_demod_out_reg == '0))
        else $error("negative phase step gave positive output");

endmodule

>>> src/fpd_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps

module fpd_mul #(
    parameter int MUL_W = 19
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [MUL_W-1:0]   op_a,
    input  logic signed [MUL_W-1:0]   op_b,
    output logic signed [2*MUL_W-1:0] prod
);

    logic signed [2*MUL_W-1:0] prod_reg;

    // Product holds while not enabled
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

>>> src/fpd_div.sv
// Radix-2 restoring divider: rounded (num << 16) / den, one quotient bit per cycle.
`timescale 1ns / 1ps

module fpd_div #(
    parameter int DEN_W = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [DEN_W-1:0]           num,
    input  logic [DEN_W-1:0]           den,
    output logic                       busy,
    output logic [fpd_pkg::QUOT_W-1:0] quot
);

    localparam int QW    = fpd_pkg::QUOT_W;
    localparam int DVD_W = DEN_W + QW;

    logic [DEN_W-1:0]          rem_reg;
    logic [DEN_W-1:0]          den_reg;
    logic [QW-1:0]             rq_reg;     // dividend low bits in, quotient bits out
    logic [fpd_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg;

    logic [DVD_W-1:0] dividend;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;

    // num <= den, so the quotient never exceeds 2^16
    assign dividend = DVD_W'({num, {fpd_pkg::FRAC_W{1'b0}}}) + DVD_W'(den >> 1);

    // One trial subtraction
    assign shifted = {rem_reg, rq_reg[QW-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= fpd_pkg::CNT_W'(QW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == fpd_pkg::CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Remainder and quotient shift
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[DVD_W-1:QW];
            rq_reg  <= dividend[QW-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            rq_reg  <= {rq_reg[QW-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = rq_reg;

endmodule
